// ===== hdl/sds_pkg.sv =====
// Shared constants, register indexes, mode codes and field types for the
// sonar distance smoother. No dependencies.
package sds_pkg;

    localparam int DEF_CHANNELS = 5;
    localparam int DEF_WINDOW   = 8;

    localparam int CH_W       = 3;
    localparam int DIST_W     = 10;
    localparam int MODE_W     = 2;
    localparam int MINCNT_W   = 4;
    localparam int THR_W      = 10;
    localparam int WEIGHT_W   = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    // w * reading + (256 - w) * old never exceeds 256 * 1023
    localparam int BLEND_W = DIST_W + WEIGHT_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT = 4'd3;

    localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EMA    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAW    = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    localparam logic [MODE_W-1:0]   RST_MODE      = MODE_WINDOW;
    localparam logic [MINCNT_W-1:0] RST_MIN_COUNT = 4'd2;
    localparam logic [THR_W-1:0]    RST_NEAR_THR  = 10'd30;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 9'd64;

    typedef logic [CH_W-1:0]       t_channel;
    typedef logic [DIST_W-1:0]     t_dist;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

endpackage

// ===== hdl/sds_in_if.sv =====
// Request channel carrying one distance reading.
// Depends on sds_pkg.
interface sds_in_if;
    import sds_pkg::*;

    logic     valid;
    logic     ready;
    t_channel channel;
    t_dist    distance_cm;

    modport source (output valid, channel, distance_cm, input ready);
    modport sink   (input valid, channel, distance_cm, output ready);
endinterface

// ===== hdl/sds_out_if.sv =====
// Result channel carrying one smoothed distance and near flag.
// Depends on sds_pkg.
interface sds_out_if;
    import sds_pkg::*;

    logic     valid;
    logic     ready;
    t_channel channel_out;
    t_dist    mean_cm;
    logic     is_near;

    modport source (output valid, channel_out, mean_cm, is_near, input ready);
    modport sink   (input valid, channel_out, mean_cm, is_near, output ready);
endinterface

// ===== hdl/sds_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on sds_pkg.
interface sds_cfg_if;
    import sds_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sonar_distance_smoother_unit.sv =====
// Top level of the sonar distance smoother: config registers, sequencer,
// per-channel history RAM and mean store. Depends on sds_pkg, the channel
// interfaces, sds_ram, sds_div and sds_blend.
//
//   channel  dir  payload                          accepted when
//   i_cfg    in   index, data                      valid & ready (ready always 1)
//   i_in     in   channel, distance_cm             valid & ready
//   o_out    out  channel_out, mean_cm, is_near    valid & ready
//
// One request at a time. Window mode walks the history RAM serially (one
// entry a cycle) and then, if enough entries were counted, runs the
// one-bit-a-cycle divider. Exponential mode runs the serial blend. Raw mode
// and an unknown channel go straight to the result step. A new request is
// taken while a result waits on o_out; the block stalls in its last step
// only if the held result is not taken.
// Reset is synchronous; history needs no clearing pass since per-channel
// fill counts mask entries never written.
module sonar_distance_smoother_unit #(
    parameter int CHANNELS = sds_pkg::DEF_CHANNELS,
    parameter int WINDOW   = sds_pkg::DEF_WINDOW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sds_cfg_if.sink      i_cfg,
    sds_in_if.sink       i_in,
    sds_out_if.source    o_out
);
    import sds_pkg::*;

    localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = DIST_W + FILL_W;
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DIVIDE = 3'd3;
    localparam logic [2:0] S_BLEND  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // configuration
    logic [MODE_W-1:0]   r_mode_cfg;
    logic [MINCNT_W-1:0] r_min_cnt;
    logic [THR_W-1:0]    r_thr;
    logic [WEIGHT_W-1:0] r_weight;

    // sequencer and request
    logic [2:0]  r_state;
    t_channel    r_ch;
    t_dist       r_dist;
    logic        r_ch_ok;
    t_dist       r_mean;
    logic        r_div_go;
    logic        r_blend_go;

    // per-channel state
    logic [SLOT_W-1:0] r_wp   [CHANNELS];
    logic [FILL_W-1:0] r_fill [CHANNELS];
    t_dist             r_mean_store [CHANNELS];

    // history walk
    logic [FILL_W-1:0] r_fill_cur;
    logic [FILL_W-1:0] r_slot;
    logic              r_rd_vld;
    logic [FILL_W-1:0] r_rd_slot;
    logic [SUM_W-1:0]  r_sum;
    logic [FILL_W-1:0] r_cnt;

    // result register
    logic     r_out_valid;
    t_channel r_out_ch;
    t_dist    r_out_mean;
    logic     r_out_near;

    logic [CH_IW-1:0]    w_ch_idx;
    logic [ADDR_W-1:0]   w_base;
    logic [ADDR_W-1:0]   w_addr;
    logic                w_we;
    t_dist               w_rdata;
    logic                w_accept;
    logic                w_in_ok;
    logic                w_out_free;
    logic                w_scan_end;
    logic [WEIGHT_W-1:0] w_weight_sat;
    logic                w_div_done;
    logic [DIST_W-1:0]   w_quot;
    logic                w_blend_done;
    t_dist               w_blend_mean;
    logic [SLOT_W-1:0]   w_wp_cur;
    logic [FILL_W-1:0]   w_fill_cur;

    assign w_ch_idx     = CH_IW'(r_ch);
    assign w_base       = ADDR_W'(32'(w_ch_idx) * WINDOW);
    assign w_wp_cur     = r_wp[w_ch_idx];
    assign w_fill_cur   = r_fill[w_ch_idx];
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_in_ok      = 32'(i_in.channel) < CHANNELS;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_scan_end   = (r_slot == FILL_W'(WINDOW)) && !r_rd_vld;
    assign w_weight_sat = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;

    assign w_we   = (r_state == S_WRITE);
    assign w_addr = (r_state == S_WRITE) ? w_base + ADDR_W'(w_wp_cur)
                                         : w_base + ADDR_W'(r_slot);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    assign o_out.valid       = r_out_valid;
    assign o_out.channel_out = r_out_ch;
    assign o_out.mean_cm     = r_out_mean;
    assign o_out.is_near     = r_out_near;

    sds_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_dist),
        .o_rdata (w_rdata)
    );

    sds_div #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W),
        .Q_W   (DIST_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_sum),
        .i_den   (r_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    sds_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_blend_go),
        .i_weight  (w_weight_sat),
        .i_reading (r_dist),
        .i_old     (r_mean_store[w_ch_idx]),
        .o_done    (w_blend_done),
        .o_mean    (w_blend_mean)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cfg <= RST_MODE;
            r_min_cnt  <= RST_MIN_COUNT;
            r_thr      <= RST_NEAR_THR;
            r_weight   <= RST_WEIGHT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MODE:       r_mode_cfg <= i_cfg.data[MODE_W-1:0];
                REG_MIN_COUNT:  r_min_cnt  <= i_cfg.data[MINCNT_W-1:0];
                REG_NEAR_THR:   r_thr      <= i_cfg.data[THR_W-1:0];
                REG_EMA_WEIGHT: r_weight   <= i_cfg.data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_blend_go  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c]         <= '0;
                r_fill[c]       <= '0;
                r_mean_store[c] <= '0;
            end
        end else begin
            r_div_go   <= 1'b0;
            r_blend_go <= 1'b0;
            r_rd_vld   <= (r_state == S_SCAN) && (r_slot != FILL_W'(WINDOW));

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!w_in_ok) begin
                            r_state <= S_FINISH;
                        end else begin
                            case (r_mode_cfg)
                                MODE_WINDOW: r_state <= S_WRITE;
                                MODE_EMA: begin
                                    r_state    <= S_BLEND;
                                    r_blend_go <= 1'b1;
                                end
                                default: r_state <= S_FINISH;
                            endcase
                        end
                    end
                end
                S_WRITE: begin
                    // newest reading overwrites the oldest slot of the ring
                    r_wp[w_ch_idx] <= (w_wp_cur == SLOT_W'(WINDOW - 1))
                                      ? '0 : w_wp_cur + 1'b1;
                    if (w_fill_cur != FILL_W'(WINDOW)) begin
                        r_fill[w_ch_idx] <= w_fill_cur + 1'b1;
                        r_fill_cur       <= w_fill_cur + 1'b1;
                    end else begin
                        r_fill_cur <= w_fill_cur;
                    end
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        if (32'(r_cnt) > 32'(r_min_cnt) && r_cnt != '0) begin
                            r_state  <= S_DIVIDE;
                            r_div_go <= 1'b1;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_DIVIDE: begin
                    if (w_div_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_BLEND: begin
                    if (w_blend_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_ch_ok) begin
                            r_mean_store[w_ch_idx] <= r_mean;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request payload, history walk and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_ch    <= i_in.channel;
                    r_dist  <= i_in.distance_cm;
                    r_ch_ok <= w_in_ok;
                    r_mean  <= (w_in_ok && r_mode_cfg != MODE_WINDOW
                                && r_mode_cfg != MODE_EMA) ? i_in.distance_cm : '0;
                end
            end
            S_WRITE: begin
                r_slot <= '0;
                r_sum  <= '0;
                r_cnt  <= '0;
            end
            S_SCAN: begin
                if (r_slot != FILL_W'(WINDOW)) begin
                    r_slot <= r_slot + 1'b1;
                end
                r_rd_slot <= r_slot;
                // slots past the fill count were never written and are masked out; zero readings are skipped too
                if (r_rd_vld && r_rd_slot < r_fill_cur && w_rdata != '0) begin
                    r_sum <= r_sum + SUM_W'(w_rdata);
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_scan_end) begin
                    r_mean <= '0;
                end
            end
            S_DIVIDE: begin
                if (w_div_done) begin
                    r_mean <= w_quot;
                end
            end
            S_BLEND: begin
                if (w_blend_done) begin
                    r_mean <= w_blend_mean;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    r_out_ch   <= r_ch;
                    r_out_mean <= r_mean;
                    r_out_near <= (r_mean != '0) && (r_mean < r_thr);
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== hdl/sds_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module sds_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/sds_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sds_pkg only through the top level that sizes it.
module sds_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 4,
    parameter int Q_W   = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_step;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_fits;

    // remainder stays below the divisor, so trial < 2 * divisor
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[Q_W-1:0];
endmodule

// ===== hdl/sds_blend.sv =====
// Bit-serial blend: (w * reading + (256 - w) * old) >> 8, one weight bit
// per cycle. Depends on sds_pkg.
module sds_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sds_pkg::WEIGHT_W-1:0]   i_weight,
    input  sds_pkg::t_dist                 i_reading,
    input  sds_pkg::t_dist                 i_old,
    output logic                           o_done,
    output sds_pkg::t_dist                 o_mean
);
    import sds_pkg::*;

    localparam int CNT_W = $clog2(WEIGHT_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_step;
    logic [WEIGHT_W-1:0] r_wa;
    logic [WEIGHT_W-1:0] r_wb;
    logic [BLEND_W-1:0]  r_ra;
    logic [BLEND_W-1:0]  r_rb;
    logic [BLEND_W-1:0]  r_acc;

    logic [BLEND_W-1:0] w_pa;
    logic [BLEND_W-1:0] w_pb;

    assign w_pa = r_wa[0] ? r_ra : '0;
    assign w_pb = r_wb[0] ? r_rb : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == CNT_W'(WEIGHT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_wa  <= i_weight;
            r_wb  <= WEIGHT_ONE - i_weight;
            r_ra  <= BLEND_W'(i_reading);
            r_rb  <= BLEND_W'(i_old);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pa + w_pb;
            r_wa  <= r_wa >> 1;
            r_wb  <= r_wb >> 1;
            r_ra  <= r_ra << 1;
            r_rb  <= r_rb << 1;
        end
    end

    assign o_done = r_done;
    assign o_mean = r_acc[WEIGHT_W-1 +: DIST_W];
endmodule
